// File: rtl/hcbd_pkg.sv
// Package for the HTTP chunked body decoder: widths, result status codes,
// the output queue entry type and byte classification helpers. No dependencies.
package hcbd_pkg;

  // Chunk length width; sizes above 2^LEN_BITS-1 overflow
  localparam int unsigned LEN_BITS = 24;
  localparam int unsigned DISC_W   = 24;

  // Output queue: room for the two results one byte can cause, plus slack
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [7:0]          byte_t;
  typedef logic [1:0]          status_t;
  typedef logic [DISC_W-1:0]   discard_t;
  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [LEN_BITS:0]   acc_t;   // one spare bit holds the saturated value

  // End status codes
  localparam status_t ST_ZERO_SIZE = 2'd0;
  localparam status_t ST_CLEAN     = 2'd1;
  localparam status_t ST_IN_DATA   = 2'd2;
  localparam status_t ST_OVERFLOW  = 2'd3;

  // Characters of interest
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_PLUS  = 8'h2B;
  localparam byte_t CH_MINUS = 8'h2D;
  localparam byte_t CH_ZERO  = 8'h30;
  localparam byte_t CH_X_LO  = 8'h78;
  localparam byte_t CH_X_UP  = 8'h58;

  typedef struct packed {
    byte_t    out_byte;
    logic     is_end;
    status_t  end_status;
    discard_t discard_count;
  } res_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_decode(input byte_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Leading whitespace accepted before the size: space, TAB, LF, VT, FF, CR
  function automatic logic is_space(input byte_t c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// File: rtl/hcbd_in_if.sv
// Input channel of the chunked body decoder: one body byte per transfer.
// Depends on hcbd_pkg.
interface hcbd_in_if;
  logic           valid;
  logic           ready;
  hcbd_pkg::byte_t in_byte;
  logic           in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/hcbd_out_if.sv
// Result channel of the chunked body decoder: payload byte or end status.
// Depends on hcbd_pkg.
interface hcbd_out_if;
  logic               valid;
  logic               ready;
  hcbd_pkg::byte_t    out_byte;
  logic               is_end;
  hcbd_pkg::status_t  end_status;
  hcbd_pkg::discard_t discard_count;

  modport source (output valid, output out_byte, output is_end, output end_status,
                  output discard_count, input ready);
  modport sink   (input valid, input out_byte, input is_end, input end_status,
                  input discard_count, output ready);
endinterface

// File: rtl/http_chunked_body_decoder_unit.sv
// HTTP/1.1 chunked body decoder. Takes the body one byte per input transfer
// and gives each chunk's data bytes as payload results (is_end = 0). A size
// line ends at CR LF; the size is read as base-16 with optional leading
// whitespace, sign and 0x prefix, and the first non-digit (';' for extensions
// among them) ends the digits. A zero, negative or overflowing size ends the
// body; later bytes give nothing. Two bytes after each chunk's data are
// skipped unchecked. A byte with in_last set is processed and then followed
// by an end result (is_end = 1) carrying the status and, for a body cut off
// inside chunk data, the number of already delivered bytes of that chunk to
// drop; the decoder then returns to its reset state. Rate: one byte per clock
// while the output queue has room. The byte is decoded in the cycle of its
// transfer and its results (at most two) are written to a four-entry output
// queue; the input is ready whenever two entries are free, so a byte is taken
// every cycle as long as the consumer keeps up, and results are registered.
// No clearing pass after reset. Depends on hcbd_pkg, hcbd_in_if, hcbd_out_if.
module http_chunked_body_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbd_in_if.sink     in_i,
  hcbd_out_if.source  out_o
);

  // Parser modes
  localparam logic [2:0] M_PRE    = 3'd0;  // size line, before the sign
  localparam logic [2:0] M_SIGNED = 3'd1;  // after sign, before first digit
  localparam logic [2:0] M_ZERO   = 3'd2;  // leading '0' seen, 0x may follow
  localparam logic [2:0] M_DIGITS = 3'd3;  // inside hex digits
  localparam logic [2:0] M_DATA   = 3'd5;  // chunk data
  localparam logic [2:0] M_SKIP   = 3'd6;  // two trailing bytes after data

  localparam hcbd_pkg::acc_t LIMIT =
    hcbd_pkg::acc_t'((64'd1 << hcbd_pkg::LEN_BITS) - 64'd1);
  localparam hcbd_pkg::acc_t SAT = LIMIT + hcbd_pkg::acc_t'(1);

  // Parser state
  logic [2:0]            mode_q, mode_d;
  hcbd_pkg::acc_t        accum_q, accum_d;
  logic                  neg_q, neg_d;
  logic                  closed_q, closed_d;
  logic                  saw_cr_q, saw_cr_d;
  hcbd_pkg::len_t        left_q, left_d;
  hcbd_pkg::len_t        emitted_q, emitted_d;
  logic                  fin_q, fin_d;
  hcbd_pkg::status_t     fin_st_q, fin_st_d;

  // Output queue
  hcbd_pkg::res_t                     mem_q [hcbd_pkg::FIFO_DEPTH];
  logic [hcbd_pkg::PTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [hcbd_pkg::PTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [hcbd_pkg::PTR_W-1:0]         wr_ptr_nxt;
  logic [hcbd_pkg::CNT_W-1:0]         count_q, count_d;

  logic                  accept;
  logic                  pop;
  hcbd_pkg::byte_t       c;
  logic [4:0]            hex;
  logic [hcbd_pkg::LEN_BITS+4:0] acc_wide;
  hcbd_pkg::acc_t        acc_digit;
  logic [1:0]            push_n;
  hcbd_pkg::res_t        res0, res1;
  hcbd_pkg::res_t        data_res, end_res;
  logic                  data_push;
  hcbd_pkg::status_t     end_st;
  hcbd_pkg::len_t        emitted_nxt;

  assign accept = in_i.valid && in_i.ready;
  assign pop    = out_o.valid && out_o.ready;
  assign c      = in_i.in_byte;
  assign hex    = hcbd_pkg::hex_decode(c);

  // Ready while the queue has room for the worst case of two results
  assign in_i.ready = (count_q <= hcbd_pkg::CNT_W'(hcbd_pkg::FIFO_DEPTH - 2));

  // Next accumulator value on a digit, saturated just past the length limit
  assign acc_wide  = {accum_q, 4'h0} | (hcbd_pkg::LEN_BITS + 5)'(hex[3:0]);
  assign acc_digit = (acc_wide > (hcbd_pkg::LEN_BITS + 5)'(LIMIT)) ? SAT
                                                                   : acc_wide[hcbd_pkg::LEN_BITS:0];

  always_comb begin
    mode_d    = mode_q;
    accum_d   = accum_q;
    neg_d     = neg_q;
    closed_d  = closed_q;
    saw_cr_d  = saw_cr_q;
    left_d    = left_q;
    emitted_d = emitted_q;
    fin_d     = fin_q;
    fin_st_d  = fin_st_q;
    data_push = 1'b0;
    end_st    = hcbd_pkg::ST_CLEAN;

    if (accept) begin
      if (!fin_q) begin
        case (mode_q)
          M_DATA: begin
            data_push = 1'b1;
            emitted_d = emitted_q + hcbd_pkg::len_t'(1);
            left_d    = left_q - hcbd_pkg::len_t'(1);
            if (left_q == hcbd_pkg::len_t'(1)) begin
              left_d = hcbd_pkg::len_t'(2);
              mode_d = M_SKIP;
            end
          end
          M_SKIP: begin
            left_d = left_q - hcbd_pkg::len_t'(1);
            if (left_q == hcbd_pkg::len_t'(1)) begin
              // next size line
              mode_d   = M_PRE;
              accum_d  = '0;
              neg_d    = 1'b0;
              closed_d = 1'b0;
              saw_cr_d = 1'b0;
            end
          end
          default: begin
            if (saw_cr_q && c == hcbd_pkg::CH_LF) begin
              // end of size line: judge the size
              saw_cr_d = 1'b0;
              if (neg_q || accum_q == '0) begin
                fin_d    = 1'b1;
                fin_st_d = hcbd_pkg::ST_ZERO_SIZE;
              end else if (accum_q > LIMIT) begin
                fin_d    = 1'b1;
                fin_st_d = hcbd_pkg::ST_OVERFLOW;
              end else begin
                left_d    = accum_q[hcbd_pkg::LEN_BITS-1:0];
                emitted_d = '0;
                mode_d    = M_DATA;
              end
            end else begin
              saw_cr_d = (c == hcbd_pkg::CH_CR);
              if (!closed_q) begin
                if (mode_q == M_PRE && hcbd_pkg::is_space(c)) begin
                  // leading whitespace, nothing to do
                end else if (mode_q == M_PRE &&
                             (c == hcbd_pkg::CH_PLUS || c == hcbd_pkg::CH_MINUS)) begin
                  neg_d  = (c == hcbd_pkg::CH_MINUS);
                  mode_d = M_SIGNED;
                end else if (mode_q == M_PRE || mode_q == M_SIGNED) begin
                  if (c == hcbd_pkg::CH_ZERO) begin
                    accum_d = '0;
                    mode_d  = M_ZERO;
                  end else if (hex[4]) begin
                    accum_d = acc_digit;
                    mode_d  = M_DIGITS;
                  end else begin
                    mode_d   = M_SIGNED;
                    closed_d = 1'b1;
                  end
                end else if (mode_q == M_ZERO &&
                             (c == hcbd_pkg::CH_X_LO || c == hcbd_pkg::CH_X_UP)) begin
                  mode_d = M_DIGITS;
                end else if (hex[4]) begin
                  accum_d = acc_digit;
                  mode_d  = M_DIGITS;
                end else begin
                  closed_d = 1'b1;
                end
              end
            end
          end
        endcase
      end

      if (in_i.in_last) begin
        // status from the state left by this byte, then back to reset
        if (fin_d) begin
          end_st = fin_st_d;
        end else if (mode_d == M_DATA) begin
          end_st = hcbd_pkg::ST_IN_DATA;
        end else begin
          end_st = hcbd_pkg::ST_CLEAN;
        end
        mode_d    = M_PRE;
        accum_d   = '0;
        neg_d     = 1'b0;
        closed_d  = 1'b0;
        saw_cr_d  = 1'b0;
        left_d    = '0;
        fin_d     = 1'b0;
        fin_st_d  = hcbd_pkg::ST_ZERO_SIZE;
      end
    end
  end

  // Result items
  always_comb begin
    data_res               = '0;
    data_res.out_byte      = c;
    end_res                = '0;
    end_res.is_end         = 1'b1;
    end_res.end_status     = end_st;
    if (end_st == hcbd_pkg::ST_IN_DATA) begin
      end_res.discard_count = hcbd_pkg::discard_t'(emitted_d);
    end
  end

  always_comb begin
    push_n = 2'd0;
    res0   = data_res;
    res1   = end_res;
    if (accept) begin
      if (data_push && in_i.in_last) begin
        push_n = 2'd2;
      end else if (data_push) begin
        push_n = 2'd1;
      end else if (in_i.in_last) begin
        push_n = 2'd1;
        res0   = end_res;
      end
    end
  end

  // emitted_d is cleared on the last byte only after the status is taken
  assign emitted_nxt = (accept && in_i.in_last) ? '0 : emitted_d;

  // Queue pointers
  assign wr_ptr_nxt = wr_ptr_q + hcbd_pkg::PTR_W'(1);
  assign wr_ptr_d   = wr_ptr_q + hcbd_pkg::PTR_W'(push_n);
  assign rd_ptr_d   = rd_ptr_q + hcbd_pkg::PTR_W'(pop);
  assign count_d    = count_q + hcbd_pkg::CNT_W'(push_n) - hcbd_pkg::CNT_W'(pop);

  assign out_o.valid         = (count_q != '0);
  assign out_o.out_byte      = mem_q[rd_ptr_q].out_byte;
  assign out_o.is_end        = mem_q[rd_ptr_q].is_end;
  assign out_o.end_status    = mem_q[rd_ptr_q].end_status;
  assign out_o.discard_count = mem_q[rd_ptr_q].discard_count;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_ptr_nxt] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_PRE;
      accum_q   <= '0;
      neg_q     <= 1'b0;
      closed_q  <= 1'b0;
      saw_cr_q  <= 1'b0;
      left_q    <= '0;
      emitted_q <= '0;
      fin_q     <= 1'b0;
      fin_st_q  <= hcbd_pkg::ST_ZERO_SIZE;
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      count_q   <= '0;
    end else begin
      mode_q    <= mode_d;
      accum_q   <= accum_d;
      neg_q     <= neg_d;
      closed_q  <= closed_d;
      saw_cr_q  <= saw_cr_d;
      left_q    <= left_d;
      emitted_q <= emitted_nxt;
      fin_q     <= fin_d;
      fin_st_q  <= fin_st_d;
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      count_q   <= count_d;
    end
  end

endmodule
